/* hw/rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int CAPACITY   = 64;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int OBUF_DEPTH = 4;
	localparam int OPTR_W     = $clog2(OBUF_DEPTH);
	localparam int OLVL_W     = $clog2(OBUF_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_UPDATE = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LIST   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_DUP     = 3'd2,
		ST_MISSING = 3'd3,
		ST_NEG     = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] key;
		logic [30:0] qty;
		logic [63:0] name;
	} record_t;

	typedef struct packed {
		status_t     status;
		logic        entry_valid;
		logic [31:0] key;
		logic [30:0] qty;
		logic [63:0] name;
		logic        last;
	} result_t;

endpackage

/* hw/rtl/krt_obuf.sv */
// ----------------------------------------------------------------------------
// krt_obuf
// Small result queue in front of the output channel. It reports its fill
// level so that the sequencer can reserve room before it reads a record.
// ----------------------------------------------------------------------------
module krt_obuf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  krt_pkg::result_t               push_data,
	output logic [krt_pkg::OLVL_W-1:0]     level,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output krt_pkg::result_t               rsp_data
);
	import krt_pkg::*;

	result_t             buf_q [OBUF_DEPTH];
	logic [OPTR_W-1:0]   wr_ptr_q;
	logic [OPTR_W-1:0]   rd_ptr_q;
	logic [OLVL_W-1:0]   level_q;
	logic                pop;

	assign rsp_valid = (level_q != '0);
	assign pop       = rsp_valid && !rsp_stall;
	assign rsp_data  = buf_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OPTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + OLVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - OLVL_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// Ordered table of keyed records with insert, update, remove and list.
// Insert, update and remove search for the key, reading one table entry per cycle;
// remove then shifts the later entries down at one entry per cycle. List sends
// one beat per cycle while the result queue has room.
// One request is in work at a time; the single table read port sets the rate.
// Reset clears the entry count and the control state; the table memory is not cleared.
// ----------------------------------------------------------------------------
module keyed_record_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] key,
	input  logic signed [31:0] quantity,
	input  logic [63:0]        name_word,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic               entry_valid,
	output logic signed [31:0] entry_key,
	output logic [30:0]        entry_quantity,
	output logic [63:0]        entry_name,
	output logic               last
);
	import krt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_SHIFT  = 5'b00100,
		S_LIST   = 5'b01000,
		S_REPLY  = 5'b10000
	} state_t;

	record_t           table_mem [CAPACITY];

	state_t            state_q, state_d;
	opcode_t           op_q;
	logic [31:0]       key_q;
	logic [31:0]       quantity_q;
	logic [63:0]       name_q;
	status_t           status_q, status_d;
	logic [CNT_W-1:0]  entry_count_q;
	logic [CNT_W-1:0]  rd_idx_q;

	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	record_t           rd_rec_s1;

	logic              accept;
	logic              neg;
	logic              hit;
	logic              scan_more;
	logic              credit;
	logic              rd_issue;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	record_t           mem_wdata;
	logic              cnt_inc;
	logic              cnt_dec;
	logic              rd_load_next;
	logic              push;
	result_t           push_data;
	result_t           rsp_data;
	logic [OLVL_W-1:0] obuf_level;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign neg       = quantity_q[31];
	assign hit       = rd_vld_s1 && (rd_rec_s1.key == key_q);
	assign scan_more = (rd_idx_q < entry_count_q);
	assign credit    = ({1'b0, obuf_level} + (OLVL_W + 1)'(rd_vld_s1))
		< (OLVL_W + 1)'(OBUF_DEPTH);

	always_comb begin
		state_d      = state_q;
		status_d     = status_q;
		rd_issue     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = rd_idx_s1;
		mem_wdata    = rd_rec_s1;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		rd_load_next = 1'b0;
		push         = 1'b0;
		push_data    = '{status: ST_OK, entry_valid: 1'b0, key: '0, qty: '0,
			name: '0, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = ST_OK;
					priority if (opcode_t'(opcode) == OP_LIST) begin
						state_d = (entry_count_q == '0) ? S_REPLY : S_LIST;
					end else if (opcode_t'(opcode) == OP_INSERT
						&& entry_count_q == CNT_W'(CAPACITY)) begin
						status_d = ST_FULL;
						state_d  = S_REPLY;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				rd_issue = scan_more && !hit;
				if (hit) begin
					unique case (op_q)
						OP_INSERT: begin
							status_d = ST_DUP;
							state_d  = S_REPLY;
						end
						OP_UPDATE: begin
							if (neg) begin
								status_d = ST_NEG;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = '{key: rd_rec_s1.key, qty: quantity_q[30:0],
									name: rd_rec_s1.name};
							end
							state_d = S_REPLY;
						end
						OP_REMOVE: begin
							rd_load_next = 1'b1;
							state_d      = S_SHIFT;
						end
						default: begin
							state_d = S_REPLY;
						end
					endcase
				end else if (!scan_more && !rd_vld_s1) begin
					if (op_q == OP_INSERT) begin
						if (neg) begin
							status_d = ST_NEG;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = entry_count_q[IDX_W-1:0];
							mem_wdata = '{key: key_q, qty: quantity_q[30:0], name: name_q};
							cnt_inc   = 1'b1;
						end
					end else begin
						status_d = ST_MISSING;
					end
					state_d = S_REPLY;
				end
			end
			S_SHIFT: begin
				rd_issue = scan_more;
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - IDX_W'(1);
				end
				if (!scan_more && !rd_vld_s1) begin
					cnt_dec = 1'b1;
					state_d = S_REPLY;
				end
			end
			S_LIST: begin
				rd_issue = scan_more && credit;
				if (rd_vld_s1) begin
					push      = 1'b1;
					push_data = '{status: ST_OK, entry_valid: 1'b1, key: rd_rec_s1.key,
						qty: rd_rec_s1.qty, name: rd_rec_s1.name,
						last: (({1'b0, rd_idx_s1} + CNT_W'(1)) == entry_count_q)};
				end
				if (!scan_more && !rd_vld_s1) begin
					state_d = S_IDLE;
				end
			end
			S_REPLY: begin
				if (obuf_level < OLVL_W'(OBUF_DEPTH)) begin
					push      = 1'b1;
					push_data = '{status: status_q, entry_valid: 1'b0, key: '0, qty: '0,
						name: '0, last: 1'b1};
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rd_rec_s1 <= table_mem[rd_idx_q[IDX_W-1:0]];
			rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (accept) begin
			op_q       <= opcode_t'(opcode);
			key_q      <= key;
			quantity_q <= quantity;
			name_q     <= name_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			status_q      <= ST_OK;
			entry_count_q <= '0;
			rd_idx_q      <= '0;
			rd_vld_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			status_q  <= status_d;
			rd_vld_s1 <= rd_issue;
			if (cnt_inc) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				entry_count_q <= entry_count_q - CNT_W'(1);
			end
			priority if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_load_next) begin
				rd_idx_q <= {1'b0, rd_idx_s1} + CNT_W'(1);
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
		end
	end

	krt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.level     (obuf_level),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	assign status         = rsp_data.status;
	assign entry_valid    = rsp_data.entry_valid;
	assign entry_key      = rsp_data.key;
	assign entry_quantity = rsp_data.qty;
	assign entry_name     = rsp_data.name;
	assign last           = rsp_data.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(CAPACITY))
		else $error("Entry count exceeds the table capacity.");

	a_obuf_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (obuf_level < OLVL_W'(OBUF_DEPTH)))
		else $error("Result beat pushed into a full queue.");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SEARCH || state_q == S_SHIFT))
		else $error("Table write outside search or shift.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("Accepted request left the sequencer idle.");

endmodule
